>>> hw/rtl/ptcs_pkg.sv
package ptcs_pkg;

    // command codes carried in the input tuser bit
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_CHAR  = 1'b1;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] LETTER_FIRST = 8'h41;
    localparam logic [7:0] LETTER_LAST  = 8'h5A;

    localparam int          NUM_GLYPHS = 26;
    localparam logic [2:0]  GAP_STEP   = 3'd5;
    localparam logic [5:0]  COL_MAX    = 6'd63;
    localparam logic [5:0]  COL_RAMP   = 6'd43;
    localparam logic [3:0]  CHARS_MAX  = 4'd15;

    localparam logic [11:0] DELAY_FIRST = 12'd1000;
    localparam logic [11:0] DELAY_FLAT  = 12'd750;
    localparam logic [11:0] DELAY_STEP  = 12'd40;
    localparam logic [11:0] DELAY_RESET = 12'd2000;
    localparam logic [11:0] DELAY_MAX   = 12'd4095;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic [7:0]  column_bits;
        logic [11:0] on_time_us;
        logic        last;
    } col_t;

    // 5x8 font, column 0 in the top byte
    localparam logic [39:0] GLYPH_ROM [NUM_GLYPHS] = '{
        40'h3F_48_88_48_3F, 40'hFF_91_91_91_6E, 40'h7E_81_81_81_42,
        40'hFF_81_81_81_7E, 40'hFF_91_91_91_81, 40'hFF_90_90_90_80,
        40'h7E_81_81_89_4E, 40'hFF_08_08_08_FF, 40'h81_81_FF_81_81,
        40'h82_81_FE_80_80, 40'hFF_10_10_28_C7, 40'hFF_01_01_01_01,
        40'hFF_40_30_40_FF, 40'hFF_60_18_06_FF, 40'h7E_81_81_81_7E,
        40'hFF_88_88_88_70, 40'h7E_81_85_7E_01, 40'hFF_88_88_88_77,
        40'h62_91_91_89_46, 40'h80_80_FF_80_80, 40'hFE_01_01_01_FE,
        40'hFE_01_02_04_F8, 40'hFF_02_0C_02_FF, 40'hC7_28_10_28_C7,
        40'hF0_08_07_08_F0, 40'h83_85_89_91_E1
    };

    function automatic logic [7:0] glyph_column(input logic [4:0] idx, input logic [2:0] step);
        logic [39:0] row;
        logic [7:0]  bits;
        row  = (idx < 5'(NUM_GLYPHS)) ? GLYPH_ROM[idx] : '0;
        bits = '0;
        unique case (step)
            3'd0:    bits = row[39:32];
            3'd1:    bits = row[31:24];
            3'd2:    bits = row[23:16];
            3'd3:    bits = row[15:8];
            3'd4:    bits = row[7:0];
            default: bits = '0;
        endcase
        return bits;
    endfunction

    // on-time from the column position in the sweep
    function automatic logic [11:0] col_on_time(input logic [5:0] idx, input logic [11:0] held);
        logic [12:0] grown;
        logic [11:0] t;
        grown = {1'b0, held} + {1'b0, DELAY_STEP};
        t     = DELAY_FLAT;
        priority if (idx == 6'd0)  t = DELAY_FIRST;
        else if (idx == 6'd1)      t = 12'd2350;
        else if (idx == 6'd2)      t = 12'd2200;
        else if (idx == 6'd3)      t = 12'd2050;
        else if (idx == 6'd4)      t = 12'd1900;
        else if (idx == 6'd5)      t = 12'd1750;
        else if (idx > COL_RAMP)   t = grown[12] ? DELAY_MAX : grown[11:0];
        else                       t = DELAY_FLAT;
        return t;
    endfunction

endpackage

>>> hw/rtl/ptcs_column_engine.sv
module ptcs_column_engine #(
    parameter int MAX_CHARS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  ptcs_pkg::item_t  in_item,
    output logic             col_valid,
    input  logic             col_ready,
    output ptcs_pkg::col_t   col
);

    logic            item_valid_reg, item_valid_next;
    ptcs_pkg::item_t item_reg;
    logic [2:0]      step_reg, step_next;
    logic [5:0]      col_idx_reg, col_idx_next;
    logic [11:0]     held_reg, held_next;
    logic [3:0]      chars_reg, chars_next;
    logic            done_reg, done_next;
    logic            invert_reg;

    logic        is_start, is_nul, is_letter, emit, final_col, col_fire, consume;
    logic [7:0]  glyph;
    logic [7:0]  char_off;
    logic [3:0]  chars_inc;

    always_comb
    begin
        is_start  = item_reg.cmd == ptcs_pkg::CMD_START;
        is_nul    = item_reg.char_code == ptcs_pkg::CHAR_NUL;
        is_letter = (item_reg.char_code >= ptcs_pkg::LETTER_FIRST) &&
                    (item_reg.char_code <= ptcs_pkg::LETTER_LAST);
        emit      = item_valid_reg && !is_start && !done_reg && !is_nul;
        final_col = !is_letter || (step_reg == ptcs_pkg::GAP_STEP);
        col_fire  = emit && col_ready;
        consume   = item_valid_reg && (!emit || (col_ready && final_col));
        in_ready  = !item_valid_reg || consume;

        char_off = item_reg.char_code - ptcs_pkg::LETTER_FIRST;
        glyph    = ptcs_pkg::glyph_column(char_off[4:0], step_reg);

        col_valid = emit;
        if (is_letter)
        begin
            col.column_bits = invert_reg ? ~glyph : glyph;
            col.on_time_us  = ptcs_pkg::col_on_time(col_idx_reg, held_reg);
        end
        else
        begin
            // non-letter: blank column at the held on-time, never inverted
            col.column_bits = '0;
            col.on_time_us  = held_reg;
        end
        col.last = final_col;
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        step_next       = step_reg;
        col_idx_next    = col_idx_reg;
        held_next       = held_reg;
        chars_next      = chars_reg;
        done_next       = done_reg;
        chars_inc       = (chars_reg == ptcs_pkg::CHARS_MAX) ? chars_reg : chars_reg + 4'd1;

        if (consume)
        begin
            item_valid_next = 1'b0;
            step_next       = '0;
        end
        else if (col_fire)
        begin
            step_next = step_reg + 3'd1;
        end
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end

        if (item_valid_reg && is_start)
        begin
            col_idx_next = '0;
            chars_next   = '0;
            done_next    = 1'b0;
        end
        else if (item_valid_reg && !done_reg && is_nul)
        begin
            done_next = 1'b1;
        end

        if (col_fire && is_letter)
        begin
            held_next    = col.on_time_us;
            col_idx_next = (col_idx_reg == ptcs_pkg::COL_MAX) ? col_idx_reg
                                                             : col_idx_reg + 6'd1;
        end
        if (col_fire && final_col)
        begin
            chars_next = chars_inc;
            if (chars_inc >= 4'(MAX_CHARS))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= '0;
            col_idx_reg    <= '0;
            held_reg       <= ptcs_pkg::DELAY_RESET;
            chars_reg      <= '0;
            done_reg       <= 1'b1;
            invert_reg     <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            step_reg       <= step_next;
            col_idx_reg    <= col_idx_next;
            held_reg       <= held_next;
            chars_reg      <= chars_next;
            done_reg       <= done_next;
            if (cfg_wr_en)
            begin
                invert_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_held_floor: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg >= ptcs_pkg::DELAY_FLAT)
        else $error("held on-time below floor");

    a_letter_stays: assert property (@(posedge clk) disable iff (!rst_n)
        col_fire && !final_col |=> item_valid_reg && (step_reg == $past(step_reg) + 3'd1))
        else $error("letter dropped before its gap column");

    a_letter_done_at_gap: assert property (@(posedge clk) disable iff (!rst_n)
        consume && emit && is_letter |-> step_reg == ptcs_pkg::GAP_STEP)
        else $error("letter retired early");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= ptcs_pkg::GAP_STEP)
        else $error("column step out of range");
`endif

endmodule

>>> hw/rtl/ptcs_out_stage.sv
module ptcs_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptcs_pkg::col_t  in_col,
    output logic            out_valid,
    input  logic            out_ready,
    output ptcs_pkg::col_t  out_col
);

    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    ptcs_pkg::col_t main_reg;
    ptcs_pkg::col_t skid_reg;
    logic           push, pop, load_main, load_skid;

    always_comb
    begin
        in_ready  = !skid_valid_reg;
        out_valid = main_valid_reg;
        out_col   = main_reg;
        push      = in_valid && in_ready;
        pop       = main_valid_reg && out_ready;

        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main       = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                load_main       = 1'b1;
                main_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && pop)
        begin
            main_reg <= skid_reg;
        end
        else if (load_main)
        begin
            main_reg <= in_col;
        end
        if (load_skid)
        begin
            skid_reg <= in_col;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without main entry");
`endif

endmodule

>>> hw/rtl/pov_text_column_sequencer_top.sv
// a word is held in the column engine; its columns reach m_axis from the output result register
// throughput: one column per cycle while the output stage accepts; a letter gives glyph columns
// then a gap column, a non-letter one blank column, a start, a nul or an ignored character none
// the column engine holds one word and takes the next in the cycle its last column leaves
// reset: sweep closed, column count and character count zero, held on-time 2000 us,
// inversion off, both output entries empty
module pov_text_column_sequencer_top #(
    parameter int MAX_CHARS = 10
) (
    input  logic        clk,
    input  logic        rst_n,

    // inversion register
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    // character words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,   // [0] cmd: 0 start sweep, 1 character

    // column words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] column_bits, [19:8] on_time_us, [23:20] zero
    output logic        m_axis_tlast    // last column of a character
);

    ptcs_pkg::item_t in_item;
    ptcs_pkg::col_t  eng_col;
    ptcs_pkg::col_t  out_col;
    logic            eng_valid;
    logic            eng_ready;

    assign in_item.cmd       = s_axis_tuser[0];
    assign in_item.char_code = s_axis_tdata;

    // one column per cycle from the held word while the output stage accepts, sweep state lives here
    ptcs_column_engine #(
        .MAX_CHARS (MAX_CHARS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .col_valid   (eng_valid),
        .col_ready   (eng_ready),
        .col         (eng_col)
    );

    // result register with skid entry, holds one extra column so the engine's ready is registered
    ptcs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (eng_valid),
        .in_ready  (eng_ready),
        .in_col    (eng_col),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_col   (out_col)
    );

    assign m_axis_tdata = {4'b0000, out_col.on_time_us, out_col.column_bits};
    assign m_axis_tlast = out_col.last;

endmodule
